>>> rtl/core/acrm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acrm_pkg: shared types and constants of the channel route mixer
// Holds the item, result and internal command types, the operation and
// command codes, and the default sizes of the gain table and mix store.
// ---------------------------------------------------------------------------
package acrm_pkg;

    // Default sizes, handed to the top level as parameter defaults.
    localparam int DEF_MAX_TRACKS    = 16;
    localparam int DEF_MAX_OUTPUTS   = 8;
    localparam int DEF_BLOCK_SAMPLES = 1024;

    // Operation codes of an input item.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_MIX  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // Command kinds passed from the front end to the back end.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_MIX  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Reset value of the active output count.
    localparam logic [3:0] ACTIVE_RESET = 4'd2;

    // Command queue between front and back end.
    localparam int CMDQ_AW    = 1;
    localparam int CMDQ_DEPTH = 1 << CMDQ_AW;

    typedef struct packed {
        logic [1:0]         operation;
        logic [3:0]         track_number;
        logic [2:0]         source_channel;
        logic [3:0]         track_width;
        logic signed [3:0]  assigned_output;
        logic [9:0]         sample_index;
        logic signed [23:0] sample_value;
        logic signed [15:0] gain_value;
        logic [2:0]         read_output;
    } acrm_item_t;

    typedef struct packed {
        logic signed [23:0] mixed_sample;
        logic               clipped;
    } acrm_result_t;

    // One classified command. A mix visits count buses starting at bus;
    // the gain column is either col or the bus itself.
    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         track;
        logic [3:0]         col;
        logic               col_follows_bus;
        logic [3:0]         bus;
        logic [3:0]         count;
        logic [9:0]         pos;
        logic signed [23:0] sample;
        logic signed [15:0] gain;
    } acrm_cmd_t;

endpackage

>>> rtl/core/acrm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acrm_front: item intake and routing classifier
// Holds the active output count, accepts items, checks their ranges and
// turns each one into a command with its bus range and gain column.
// ---------------------------------------------------------------------------
module acrm_front #(
    parameter int MAX_TRACKS    = acrm_pkg::DEF_MAX_TRACKS,
    parameter int MAX_OUTPUTS   = acrm_pkg::DEF_MAX_OUTPUTS,
    parameter int BLOCK_SAMPLES = acrm_pkg::DEF_BLOCK_SAMPLES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [3:0]          cfg_data,
    input  logic                push,
    output logic                full,
    input  acrm_pkg::acrm_item_t item,
    input  logic                q_full,
    input  logic                clearing,
    output logic                cmd_push,
    output acrm_pkg::acrm_cmd_t cmd
);
    import acrm_pkg::*;

    logic [3:0] active_reg;
    logic [3:0] active_next;
    logic [3:0] act;
    logic       track_ok;
    logic       pos_ok;
    logic       ch_ok;
    logic       mix_ok;
    logic       asg_neg;
    logic [3:0] asg_u;
    logic [3:0] ch4;
    logic [3:0] mc_bus;
    logic       keep;

    // The configuration register may be written at any time.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        active_next = active_reg;
        if (cfg_valid && cfg_ready)
        begin
            active_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACTIVE_RESET;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Intake stalls while the stores are cleared or the queue is full.
    assign full = clearing || q_full;

    // Range checks shared by the operations.
    always_comb
    begin
        act = active_reg;
        if (32'(active_reg) > MAX_OUTPUTS)
        begin
            act = 4'(MAX_OUTPUTS);
        end
        track_ok = 32'(item.track_number) < MAX_TRACKS;
        pos_ok   = 32'(item.sample_index) < BLOCK_SAMPLES;
        ch_ok    = 32'(item.source_channel) < MAX_OUTPUTS;
        ch4      = {1'b0, item.source_channel};
        asg_u    = $unsigned(item.assigned_output);
        asg_neg  = item.assigned_output[3];
        mix_ok   = track_ok && pos_ok && (item.track_width != 4'd0)
                   && (ch4 < item.track_width);
        mc_bus   = asg_neg ? ch4 : (asg_u + ch4);
    end

    // Classification into one command per kept item.
    always_comb
    begin
        cmd                 = '0;
        cmd.track           = item.track_number;
        cmd.pos             = item.sample_index;
        cmd.sample          = item.sample_value;
        cmd.gain            = item.gain_value;
        keep                = 1'b0;
        case (item.operation)
            OP_LOAD:
            begin
                cmd.kind = CMD_LOAD;
                cmd.col  = ch4;
                keep     = track_ok && ch_ok;
            end
            OP_MIX:
            begin
                cmd.kind = CMD_MIX;
                if (item.track_width > 4'd1)
                begin
                    // Multichannel: one bus, gain column is the channel.
                    cmd.bus   = mc_bus;
                    cmd.col   = ch4;
                    cmd.count = 4'd1;
                    keep      = mix_ok && (mc_bus < act) && ch_ok;
                end
                else if (!asg_neg)
                begin
                    // Assigned mono: one bus, gain column zero.
                    cmd.bus   = asg_u;
                    cmd.count = 4'd1;
                    keep      = mix_ok && (asg_u < act);
                end
                else
                begin
                    // Legacy mono: every active bus, column follows bus.
                    cmd.count           = act;
                    cmd.col_follows_bus = 1'b1;
                    keep                = mix_ok && (act != 4'd0);
                end
            end
            OP_READ:
            begin
                cmd.kind = CMD_READ;
                cmd.bus  = {1'b0, item.read_output};
                // A count of zero asks for a zero result without access.
                cmd.count = (32'(item.read_output) < MAX_OUTPUTS && pos_ok)
                            ? 4'd1 : 4'd0;
                keep     = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign cmd_push = push && !full && keep;

endmodule

>>> rtl/core/acrm_cmd_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acrm_cmd_fifo: command queue between front and back end
// A small register queue that lets intake and execution stall on their own.
// ---------------------------------------------------------------------------
module acrm_cmd_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  acrm_pkg::acrm_cmd_t wr_data,
    output logic                full,
    input  logic                rd_en,
    output acrm_pkg::acrm_cmd_t rd_data,
    output logic                empty
);
    import acrm_pkg::*;

    acrm_cmd_t            entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wr_ptr_reg;
    logic [CMDQ_AW-1:0]   wr_ptr_next;
    logic [CMDQ_AW-1:0]   rd_ptr_reg;
    logic [CMDQ_AW-1:0]   rd_ptr_next;
    logic [CMDQ_AW:0]     count_reg;
    logic [CMDQ_AW:0]     count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full    = count_reg == (CMDQ_AW + 1)'(CMDQ_DEPTH);
    assign empty   = count_reg == '0;
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> rtl/core/acrm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acrm_back: command execution with gain table and mix store
// Sequences gain loads, read-modify-write accumulation per routed bus and
// readout with clear, and clears both memories after reset.
// ---------------------------------------------------------------------------
module acrm_back #(
    parameter int MAX_TRACKS    = acrm_pkg::DEF_MAX_TRACKS,
    parameter int MAX_OUTPUTS   = acrm_pkg::DEF_MAX_OUTPUTS,
    parameter int BLOCK_SAMPLES = acrm_pkg::DEF_BLOCK_SAMPLES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  acrm_pkg::acrm_cmd_t   cmd,
    input  logic                  cmd_empty,
    output logic                  cmd_pop,
    output logic                  clearing,
    output logic                  empty,
    input  logic                  pop,
    output acrm_pkg::acrm_result_t result
);
    import acrm_pkg::*;

    localparam int GAIN_DEPTH = MAX_TRACKS * MAX_OUTPUTS;
    localparam int MIX_DEPTH  = MAX_OUTPUTS * BLOCK_SAMPLES;
    localparam int GA_W       = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;
    localparam int MA_W       = (MIX_DEPTH > 1) ? $clog2(MIX_DEPTH) : 1;
    localparam int CLR_DEPTH  = (GAIN_DEPTH > MIX_DEPTH) ? GAIN_DEPTH : MIX_DEPTH;
    localparam int CLR_W      = (CLR_DEPTH > 1) ? $clog2(CLR_DEPTH) : 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_RD     = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_WR     = 3'd4;
    localparam logic [2:0] ST_RESULT = 3'd5;

    // Memories: gain table (16 bit) and mix store ({clip mark, 32 bit sum}).
    logic [15:0]          gain_mem [GAIN_DEPTH];
    logic [32:0]          mix_mem  [MIX_DEPTH];

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [3:0]           route_reg;
    logic [3:0]           route_next;
    logic [CLR_W-1:0]     clr_reg;
    logic [CLR_W-1:0]     clr_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    acrm_result_t         out_data_reg;
    acrm_result_t         out_data_next;
    acrm_cmd_t            cmd_reg;
    logic signed [39:0]   prod_reg;
    logic [15:0]          gain_rdata_reg;
    logic [32:0]          mix_rdata_reg;

    logic                 load_cmd;
    logic                 load_prod;
    logic                 gain_we;
    logic [GA_W-1:0]      gain_waddr;
    logic [15:0]          gain_wdata;
    logic                 gain_re;
    logic                 mix_we;
    logic [MA_W-1:0]      mix_waddr;
    logic [32:0]          mix_wdata;
    logic                 mix_re;

    logic [3:0]           bus_cur;
    logic [3:0]           col_cur;
    logic [GA_W-1:0]      gain_addr;
    logic [MA_W-1:0]      mix_addr;
    logic                 out_free;

    logic [31:0]          acc;
    logic [39:0]          rnd;
    logic [25:0]          term;
    logic [32:0]          sum;
    logic                 ovf;
    logic [31:0]          acc_new;
    logic                 rd_sat;
    acrm_result_t         rd_res;

    // Current route: bus and gain column of this step.
    always_comb
    begin
        bus_cur   = cmd_reg.bus + route_reg;
        col_cur   = cmd_reg.col_follows_bus ? bus_cur : cmd_reg.col;
        gain_addr = GA_W'(32'(cmd_reg.track) * MAX_OUTPUTS + 32'(col_cur));
        mix_addr  = MA_W'(32'(bus_cur) * BLOCK_SAMPLES + 32'(cmd_reg.pos));
    end

    // Rounded product and saturating accumulation.
    always_comb
    begin
        acc     = mix_rdata_reg[31:0];
        rnd     = prod_reg + 40'sd8192;
        term    = rnd[39:14];
        sum     = {acc[31], acc} + {{7{term[25]}}, term};
        ovf     = sum[32] != sum[31];
        acc_new = sum[31:0];
        if (ovf)
        begin
            acc_new = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    // Readout: saturate the sum to 24 bits; an out-of-range read gives zero.
    always_comb
    begin
        rd_sat              = acc[31:23] != {9{acc[31]}};
        rd_res.mixed_sample = acc[23:0];
        rd_res.clipped      = mix_rdata_reg[32] | rd_sat;
        if (rd_sat)
        begin
            rd_res.mixed_sample = acc[31] ? 24'sh800000 : 24'sh7FFFFF;
        end
        if (cmd_reg.count == 4'd0)
        begin
            rd_res = '0;
        end
    end

    assign out_free = !out_valid_reg || pop;

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        route_next     = route_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !pop;
        out_data_next  = out_data_reg;
        load_cmd       = 1'b0;
        load_prod      = 1'b0;
        cmd_pop        = 1'b0;
        gain_we        = 1'b0;
        gain_waddr     = gain_addr;
        gain_wdata     = cmd_reg.gain;
        gain_re        = 1'b0;
        mix_we         = 1'b0;
        mix_waddr      = mix_addr;
        mix_wdata      = {ovf | mix_rdata_reg[32], acc_new};
        mix_re         = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (32'(clr_reg) < GAIN_DEPTH)
                begin
                    gain_we    = 1'b1;
                    gain_waddr = GA_W'(clr_reg);
                    gain_wdata = '0;
                end
                if (32'(clr_reg) < MIX_DEPTH)
                begin
                    mix_we    = 1'b1;
                    mix_waddr = MA_W'(clr_reg);
                    mix_wdata = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    load_cmd   = 1'b1;
                    route_next = '0;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                case (cmd_reg.kind)
                    CMD_LOAD:
                    begin
                        gain_we    = 1'b1;
                        state_next = ST_IDLE;
                    end
                    CMD_MIX:
                    begin
                        gain_re    = 1'b1;
                        mix_re     = 1'b1;
                        state_next = ST_MUL;
                    end
                    CMD_READ:
                    begin
                        mix_re     = cmd_reg.count != 4'd0;
                        state_next = (cmd_reg.count != 4'd0) ? ST_MUL : ST_RESULT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MUL:
            begin
                load_prod  = 1'b1;
                state_next = (cmd_reg.kind == CMD_READ) ? ST_RESULT : ST_WR;
            end
            ST_WR:
            begin
                mix_we = 1'b1;
                if (route_reg + 1'b1 == cmd_reg.count)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    route_next = route_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_res;
                    mix_we         = cmd_reg.count != 4'd0;
                    mix_wdata      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            route_reg     <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            route_reg     <= route_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: current command, product and result.
    always_ff @(posedge clk)
    begin
        if (load_cmd)
        begin
            cmd_reg <= cmd;
        end
        if (load_prod)
        begin
            prod_reg <= cmd_reg.sample * $signed(gain_rdata_reg);
        end
        out_data_reg <= out_data_next;
    end

    // Gain table port.
    always_ff @(posedge clk)
    begin
        if (gain_we)
        begin
            gain_mem[gain_waddr] <= gain_wdata;
        end
        if (gain_re)
        begin
            gain_rdata_reg <= gain_mem[gain_addr];
        end
    end

    // Mix store port.
    always_ff @(posedge clk)
    begin
        if (mix_we)
        begin
            mix_mem[mix_waddr] <= mix_wdata;
        end
        if (mix_re)
        begin
            mix_rdata_reg <= mix_mem[mix_addr];
        end
    end

    assign clearing = state_reg == ST_CLEAR;
    assign empty    = !out_valid_reg;
    assign result   = out_data_reg;

endmodule

>>> rtl/core/audio_channel_route_mixer.sv
`timescale 1ns / 1ps
// Order: a read passes the command queue and the back-end states idle,
// RD, MUL and RESULT, where its result is registered once the result
// register is free; a gain load is written in RD, and a mix runs RD, MUL
// and WR for each routed bus, a legacy mono mix once per active output.
// The back end takes a new command only when it is back in idle.
// Reset: after reset the block clears its memories with full held high.
// ---------------------------------------------------------------------------
// audio_channel_route_mixer: track channel to output bus mixer
// Front end classifies items into routing commands, a command queue
// decouples it from the back end that owns the gain table and mix store.
// ---------------------------------------------------------------------------
module audio_channel_route_mixer #(
    parameter int MAX_TRACKS    = acrm_pkg::DEF_MAX_TRACKS,
    parameter int MAX_OUTPUTS   = acrm_pkg::DEF_MAX_OUTPUTS,
    parameter int BLOCK_SAMPLES = acrm_pkg::DEF_BLOCK_SAMPLES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            cfg_data,
    input  logic                  push,
    output logic                  full,
    input  acrm_pkg::acrm_item_t  item,
    output logic                  empty,
    input  logic                  pop,
    output acrm_pkg::acrm_result_t result
);
    import acrm_pkg::*;

    acrm_cmd_t front_cmd;
    acrm_cmd_t head_cmd;
    logic      front_push;
    logic      q_full;
    logic      q_empty;
    logic      q_pop;
    logic      clearing;

    // Intake and classification.
    acrm_front #(
        .MAX_TRACKS    (MAX_TRACKS),
        .MAX_OUTPUTS   (MAX_OUTPUTS),
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .item      (item),
        .q_full    (q_full),
        .clearing  (clearing),
        .cmd_push  (front_push),
        .cmd       (front_cmd)
    );

    // Command queue.
    acrm_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (head_cmd),
        .empty   (q_empty)
    );

    // Execution and result register.
    acrm_back #(
        .MAX_TRACKS    (MAX_TRACKS),
        .MAX_OUTPUTS   (MAX_OUTPUTS),
        .BLOCK_SAMPLES (BLOCK_SAMPLES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (q_empty),
        .cmd_pop   (q_pop),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

>>> rtl/core/acrm_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// acrm_checker: port level checks of the channel route mixer
// Tracks outstanding read transfers and checks result and intake behavior.
// ---------------------------------------------------------------------------
module acrm_checker (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  logic                   full,
    input  acrm_pkg::acrm_item_t   item,
    input  logic                   empty,
    input  logic                   pop,
    input  acrm_pkg::acrm_result_t result
);
    import acrm_pkg::*;

    logic [3:0] pending_reg;
    logic [3:0] pending_next;
    logic       rd_in;
    logic       rd_out;

    // Reads accepted but whose results are not yet transferred.
    assign rd_in  = push && !full && (item.operation == OP_READ);
    assign rd_out = pop && !empty;

    always_comb
    begin
        pending_next = pending_reg + {3'b0, rd_in} - {3'b0, rd_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A waiting result holds until it is transferred.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed or vanished before transfer");

    // A result is offered only for an outstanding read.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pending_reg != 4'd0))
        else $error("result without an outstanding read");

    // Outstanding reads never exceed queue, command and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 4'(CMDQ_DEPTH + 2))
        else $error("too many outstanding reads");

    // The memory clearing pass blocks intake right after reset.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> full)
        else $error("intake open during clearing after reset");

endmodule

bind audio_channel_route_mixer acrm_checker u_acrm_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);

>>> dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for the audio channel route mixer
// Drives gain loads, sample mixes and readouts through the item queue,
// predicts every readout with a bit-exact model of the gain table and mix
// store, and compares each result transfer with the oldest prediction.
// A typed-in table of directed items runs first, then random phases under
// several active output counts, a saturation burst and a long result stall.
// ---------------------------------------------------------------------------
module tb;

    import acrm_pkg::*;

    localparam int     WATCHDOG_LIMIT = 40000;
    localparam int     SETTLE_CYCLES  = 150;
    localparam int     LONG_HOLD      = 400;
    localparam int     PHASE_ITEMS    = 35;
    localparam longint ACC_MAX        = 64'sd2147483647;
    localparam longint ACC_MIN        = -64'sd2147483648;
    localparam longint OUT_MAX        = 64'sd8388607;
    localparam longint OUT_MIN        = -64'sd8388608;

    typedef struct {
        acrm_item_t   it;
        bit           known;
        acrm_result_t want;
    } table_row_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [3:0]   cfg_data;
    logic         push;
    logic         full;
    acrm_item_t   item;
    logic         empty;
    logic         pop;
    acrm_result_t result;

    // Mirror of the block state.
    logic signed [15:0] gain_mem [16][8];
    logic signed [31:0] acc_mem [8][1024];
    bit                 clip_mem [8][1024];
    int                 active_cfg;

    acrm_result_t pending_samples [$];
    table_row_t   stim_table [$];

    int  error_count;
    int  items_accepted;
    int  results_checked;
    int  clipped_seen;
    int  settings_used;
    int  idle_cycles;
    bit  send_idle_on;
    bit  recv_idle_on;
    bit  long_hold_req;

    audio_channel_route_mixer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .item      (item),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    // Clock generation, 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Gap length: mostly none or short, now and then a long one.
    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic acrm_item_t make_item(logic [1:0] op, int trk, int ch, int wid,
                                             int asg, int idx, int smp, int gn, int rbus);
        acrm_item_t it;
        it.operation       = op;
        it.track_number    = trk[3:0];
        it.source_channel  = ch[2:0];
        it.track_width     = wid[3:0];
        it.assigned_output = asg[3:0];
        it.sample_index    = idx[9:0];
        it.sample_value    = smp[23:0];
        it.gain_value      = gn[15:0];
        it.read_output     = rbus[2:0];
        return it;
    endfunction

    // Sample times gain in Q2.14, rounded half up back to Q.23.
    function automatic longint apply_gain(logic signed [23:0] smp, logic signed [15:0] gn);
        longint p;
        p = longint'(smp) * longint'(gn);
        return (p + 64'sd8192) >>> 14;
    endfunction

    task automatic add_to_bus(input int bus, input int pos, input longint term);
        longint s;
        s = longint'(acc_mem[bus][pos]) + term;
        if (s > ACC_MAX)
        begin
            s = ACC_MAX;
            clip_mem[bus][pos] = 1'b1;
        end
        if (s < ACC_MIN)
        begin
            s = ACC_MIN;
            clip_mem[bus][pos] = 1'b1;
        end
        acc_mem[bus][pos] = s[31:0];
    endtask

    // Applies one item to the mirror and returns the readout it causes, if any.
    task automatic predict_mix(input acrm_item_t it, output bit has_out,
                               output acrm_result_t res);
        int     act;
        int     trk;
        int     ch;
        int     wid;
        int     asg;
        int     pos;
        int     bus;
        longint v;
        act     = (active_cfg > 8) ? 8 : active_cfg;
        trk     = int'(it.track_number);
        ch      = int'(it.source_channel);
        wid     = int'(it.track_width);
        asg     = int'($signed(it.assigned_output));
        pos     = int'(it.sample_index);
        has_out = 1'b0;
        res     = '0;
        case (it.operation)
            OP_LOAD: gain_mem[trk][ch] = it.gain_value;
            OP_MIX:
            begin
                if (wid != 0 && ch < wid)
                begin
                    if (wid > 1)
                    begin
                        bus = (asg >= 0) ? asg + ch : ch;
                        if (bus < act)
                            add_to_bus(bus, pos, apply_gain(it.sample_value, gain_mem[trk][ch]));
                    end
                    else if (asg >= 0)
                    begin
                        if (asg < act)
                            add_to_bus(asg, pos, apply_gain(it.sample_value, gain_mem[trk][0]));
                    end
                    else
                    begin
                        for (int n = 0; n < act; n++)
                            add_to_bus(n, pos, apply_gain(it.sample_value, gain_mem[trk][n]));
                    end
                end
            end
            OP_READ:
            begin
                bus         = int'(it.read_output);
                v           = longint'(acc_mem[bus][pos]);
                res.clipped = clip_mem[bus][pos];
                if (v > OUT_MAX)
                begin
                    v           = OUT_MAX;
                    res.clipped = 1'b1;
                end
                if (v < OUT_MIN)
                begin
                    v           = OUT_MIN;
                    res.clipped = 1'b1;
                end
                res.mixed_sample   = v[23:0];
                acc_mem[bus][pos]  = '0;
                clip_mem[bus][pos] = 1'b0;
                has_out            = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Offers one item and waits for its transfer; the typed-in result,
    // where given, replaces the predicted one.
    task automatic send_item(input acrm_item_t it, input bit known, input acrm_result_t want);
        int           gap;
        bit           has_out;
        acrm_result_t res;
        gap = pick_gap(send_idle_on);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_accepted++;
        predict_mix(it, has_out, res);
        if (has_out)
            pending_samples.push_back(known ? want : res);
    endtask

    task automatic add_row(input acrm_item_t it, input bit known, input int smp, input bit clip);
        table_row_t row;
        row.it                = it;
        row.known             = known;
        row.want.mixed_sample = smp[23:0];
        row.want.clipped      = clip;
        stim_table.push_back(row);
    endtask

    // Waits until every readout has come back and the back end has run dry.
    task automatic settle_block();
        push <= 1'b0;
        while (pending_samples.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_active(input int value);
        cfg_valid <= 1'b1;
        cfg_data  <= value[3:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid  <= 1'b0;
        active_cfg = value;
        settings_used++;
    endtask

    function automatic acrm_item_t random_item(bit read_heavy);
        acrm_item_t it;
        int         r;
        int         wid;
        logic [31:0] rnd;
        r = $urandom_range(0, 99);
        if (read_heavy)
            it.operation = (r < 80) ? OP_READ : OP_MIX;
        else if (r < 15)
            it.operation = OP_LOAD;
        else if (r < 70)
            it.operation = OP_MIX;
        else if (r < 95)
            it.operation = OP_READ;
        else
            it.operation = OP_NONE;
        it.track_number = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3))
                                                      : 4'($urandom_range(0, 15));
        // Mostly a channel that lies inside its track.
        if ($urandom_range(0, 99) < 85)
        begin
            wid               = $urandom_range(1, 8);
            it.track_width    = 4'(wid);
            it.source_channel = 3'($urandom_range(0, wid - 1));
        end
        else
        begin
            it.track_width    = 4'($urandom_range(0, 15));
            it.source_channel = 3'($urandom_range(0, 7));
        end
        it.assigned_output = ($urandom_range(0, 99) < 40) ? 4'hF : 4'($urandom_range(0, 15));
        it.sample_index    = ($urandom_range(0, 3) != 0) ? 10'($urandom_range(0, 7))
                                                         : 10'($urandom_range(0, 1023));
        rnd = $urandom();
        r   = $urandom_range(0, 99);
        if (r < 5)
            it.sample_value = 24'h7FFFFF;
        else if (r < 10)
            it.sample_value = 24'h800000;
        else if (r < 40)
            it.sample_value = 24'($signed(rnd[12:0]));
        else
            it.sample_value = rnd[23:0];
        rnd = $urandom();
        r   = $urandom_range(0, 99);
        if (r < 5)
            it.gain_value = 16'h7FFF;
        else if (r < 10)
            it.gain_value = 16'h8000;
        else if (r < 20)
            it.gain_value = 16'h4000;
        else if (r < 50)
            it.gain_value = 16'($signed(rnd[10:0]));
        else
            it.gain_value = rnd[15:0];
        it.read_output = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic run_random(input int count, input bit read_heavy);
        acrm_result_t none;
        none = '0;
        for (int i = 0; i < count; i++)
            send_item(random_item(read_heavy), 1'b0, none);
    endtask

    // Full-scale legacy mono sums into one position until every active
    // accumulator saturates, then reads each bus back.
    task automatic saturate_burst(input int pos, input int smp);
        acrm_result_t none;
        none = '0;
        for (int c = 0; c < 8; c++)
            send_item(make_item(OP_LOAD, 2, c, 0, 0, 0, 0, 32767, 0), 1'b0, none);
        for (int i = 0; i < 135; i++)
            send_item(make_item(OP_MIX, 2, 0, 1, -1, pos, smp, 0, 0), 1'b0, none);
        for (int b = 0; b < 8; b++)
            send_item(make_item(OP_READ, 0, 0, 0, 0, pos, 0, 0, b), 1'b0, none);
    endtask

    // Result side: random pop gaps, one long hold on request.
    initial
    begin
        int           hold_left;
        int           gap_left;
        acrm_result_t want;
        hold_left = 0;
        gap_left  = 0;
        pop <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                results_checked++;
                if (result.clipped)
                    clipped_seen++;
                if (pending_samples.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected: sample %0d clip %0b",
                             $time, result.mixed_sample, result.clipped);
                    error_count++;
                end
                else
                begin
                    want = pending_samples.pop_front();
                    if (result.mixed_sample !== want.mixed_sample)
                    begin
                        $display("%0t: mixed_sample expected %0d actual %0d",
                                 $time, want.mixed_sample, result.mixed_sample);
                        error_count++;
                    end
                    if (result.clipped !== want.clipped)
                    begin
                        $display("%0t: clipped expected %0b actual %0b",
                                 $time, want.clipped, result.clipped);
                        error_count++;
                    end
                end
                gap_left = pick_gap(recv_idle_on);
            end
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Main sequence.
    initial
    begin
        int phase_settings [7];
        error_count     = 0;
        items_accepted  = 0;
        results_checked = 0;
        clipped_seen    = 0;
        settings_used   = 0;
        idle_cycles     = 0;
        send_idle_on    = 1'b1;
        recv_idle_on    = 1'b1;
        long_hold_req   = 1'b0;
        active_cfg      = int'(ACTIVE_RESET);
        for (int t = 0; t < 16; t++)
            for (int c = 0; c < 8; c++)
                gain_mem[t][c] = '0;
        for (int b = 0; b < 8; b++)
            for (int p = 0; p < 1024; p++)
            begin
                acc_mem[b][p]  = '0;
                clip_mem[b][p] = 1'b0;
            end
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        push      <= 1'b0;
        item      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table under the reset setting of two active buses.
        add_row(make_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 0, 1'b0);
        add_row(make_item(OP_READ, 0, 0, 0, 0, 1023, 0, 0, 7), 1'b1, 0, 1'b0);
        add_row(make_item(OP_LOAD, 0, 0, 0, 0, 0, 0, 32767, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_LOAD, 0, 1, 0, 0, 0, 0, -32768, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_LOAD, 1, 0, 0, 0, 0, 0, 8192, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_LOAD, 15, 7, 0, 0, 0, 0, -1, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_LOAD, 15, 0, 0, 0, 0, 0, 16384, 0), 1'b0, 0, 1'b0);
        // Full-scale products clip at readout.
        add_row(make_item(OP_MIX, 0, 0, 1, 0, 5, 8388607, 0, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_READ, 0, 0, 0, 0, 5, 0, 0, 0), 1'b1, 8388607, 1'b1);
        add_row(make_item(OP_MIX, 0, 1, 2, -1, 6, -8388608, 0, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_READ, 0, 0, 0, 0, 6, 0, 0, 1), 1'b1, 8388607, 1'b1);
        // Rounding ties at half gain.
        add_row(make_item(OP_MIX, 1, 0, 1, 0, 7, 1, 0, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_MIX, 1, 0, 1, 1, 7, -1, 0, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_READ, 0, 0, 0, 0, 7, 0, 0, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_READ, 0, 0, 0, 0, 7, 0, 0, 1), 1'b0, 0, 1'b0);
        // Unused operation, channel outside its track, zero width, routes
        // beyond the active buses.
        add_row(make_item(OP_NONE, 15, 7, 15, -1, 1023, -1, -1, 7), 1'b0, 0, 1'b0);
        add_row(make_item(OP_MIX, 0, 2, 2, -1, 8, 8388607, 0, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_MIX, 0, 0, 0, -1, 8, 8388607, 0, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_MIX, 0, 0, 1, 5, 8, 8388607, 0, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_MIX, 15, 7, 15, 7, 9, 8388607, 0, 0), 1'b0, 0, 1'b0);
        // Legacy mono to both active buses.
        add_row(make_item(OP_MIX, 15, 0, 1, -8, 1023, -8388608, 0, 0), 1'b0, 0, 1'b0);
        add_row(make_item(OP_READ, 0, 0, 0, 0, 1023, 0, 0, 0), 1'b1, -8388608, 1'b0);
        add_row(make_item(OP_READ, 0, 0, 0, 0, 1023, 0, 0, 1), 1'b0, 0, 1'b0);
        add_row(make_item(OP_READ, 0, 0, 0, 0, 8, 0, 0, 5), 1'b1, 0, 1'b0);
        foreach (stim_table[i])
            send_item(stim_table[i].it, stim_table[i].known, stim_table[i].want);
        settle_block();

        // Random phases across the range of the active output count.
        phase_settings = '{8, 1, 0, 15, 3, 6, $urandom_range(0, 15)};
        foreach (phase_settings[i])
        begin
            send_idle_on = (i != 2);
            recv_idle_on = (i != 4);
            write_active(phase_settings[i]);
            run_random(PHASE_ITEMS, 1'b0);
            settle_block();
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;

        // Accumulator saturation in both directions.
        write_active(8);
        saturate_burst(100, 8388607);
        saturate_burst(101, -8388608);
        settle_block();

        // Long result stall while reads keep coming, so the input backs up.
        write_active(4);
        send_idle_on  = 1'b0;
        long_hold_req = 1'b1;
        run_random(60, 1'b1);
        send_idle_on  = 1'b1;
        settle_block();

        $display("Accepted %0d items under %0d active output settings.",
                 items_accepted, settings_used);
        $display("Checked %0d readouts, %0d of them clipped.", results_checked, clipped_seen);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
